// File: hdl/rbtc_pkg.sv
// Shared types and constants for the relay bank threshold controller.
`default_nettype none

package rbtc_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_W     = 3;
    localparam int MASK_W     = 8;
    localparam int INDEX_W    = 4;
    localparam int OPCODE_W   = 3;
    localparam int METER_W    = 16;

    // 250.0 V, 200.0 V in 0.1 V units; 50.00 A in 0.01 A units
    localparam logic [METER_W-1:0] VOLT_HIGH_RESET = 16'd2500;
    localparam logic [METER_W-1:0] VOLT_LOW_RESET  = 16'd2000;
    localparam logic [METER_W-1:0] CURR_HIGH_RESET = 16'd5000;
    localparam logic [MASK_W-1:0]  ALL_ON_PATTERN  = 8'hFF;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SET_ONE    = 3'd0,
        OP_SET_ALL    = 3'd1,
        OP_TOGGLE     = 3'd2,
        OP_POWER_FAIL = 3'd3,
        OP_SET_MODE   = 3'd4,
        OP_SET_LIMITS = 3'd5,
        OP_SAMPLE     = 3'd6,
        OP_QUERY      = 3'd7
    } opcode_t;

    typedef struct packed {
        opcode_t              opcode;
        logic [INDEX_W-1:0]   relay_index;
        logic                 turn_on;
        logic [MASK_W-1:0]    new_mask;
        logic                 manual_flag;
        logic                 auto_flag;
        logic [METER_W-1:0]   bus_voltage;
        logic [METER_W-1:0]   channel_current;
        logic                 sensor_present;
        logic [METER_W-1:0]   voltage_high_limit;
        logic [METER_W-1:0]   voltage_low_limit;
        logic [METER_W-1:0]   current_high_limit;
    } cmd_t;

    typedef struct packed {
        logic [MASK_W-1:0] relay_outputs;
        logic              outputs_written;
        logic              safe_mode;
        logic              index_error;
        logic              selected_on;
    } rsp_t;

endpackage

`default_nettype wire

// File: hdl/rbtc_cmd_if.sv
// Command channel: one opcode word with its operands.
`default_nettype none

interface rbtc_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [3:0]  relay_index;
    logic        turn_on;
    logic [7:0]  new_mask;
    logic        manual_flag;
    logic        auto_flag;
    logic [15:0] bus_voltage;
    logic [15:0] channel_current;
    logic        sensor_present;
    logic [15:0] voltage_high_limit;
    logic [15:0] voltage_low_limit;
    logic [15:0] current_high_limit;

    modport source (
        output valid, opcode, relay_index, turn_on, new_mask, manual_flag, auto_flag,
               bus_voltage, channel_current, sensor_present, voltage_high_limit,
               voltage_low_limit, current_high_limit,
        input  ready
    );

    modport sink (
        input  valid, opcode, relay_index, turn_on, new_mask, manual_flag, auto_flag,
               bus_voltage, channel_current, sensor_present, voltage_high_limit,
               voltage_low_limit, current_high_limit,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/rbtc_rsp_if.sv
// Response channel: relay status word after each command.
`default_nettype none

interface rbtc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] relay_outputs;
    logic       outputs_written;
    logic       safe_mode;
    logic       index_error;
    logic       selected_on;

    modport source (
        output valid, relay_outputs, outputs_written, safe_mode, index_error, selected_on,
        input  ready
    );

    modport sink (
        input  valid, relay_outputs, outputs_written, safe_mode, index_error, selected_on,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/rbtc_exec.sv
// Relay state, limit tables and the per-command update logic.
`default_nettype none

module rbtc_exec #(
    parameter int RELAY_COUNT     = 8,
    parameter int SENSED_CHANNELS = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire rbtc_pkg::cmd_t cmd,
    output rbtc_pkg::rsp_t     rsp
);
    import rbtc_pkg::*;

    localparam logic [MASK_W-1:0]  BANK_MASK   = MASK_W'((1 << RELAY_COUNT) - 1);
    localparam logic [INDEX_W-1:0] RELAY_LIMIT = INDEX_W'(RELAY_COUNT);
    localparam logic [INDEX_W-1:0] SENSE_LIMIT = INDEX_W'(SENSED_CHANNELS);

    logic [MASK_W-1:0]  on_reg, on_next;
    logic [MASK_W-1:0]  manual_reg, manual_next;
    logic [MASK_W-1:0]  auto_reg, auto_next;
    logic               safe_reg, safe_next;
    logic [METER_W-1:0] vh_reg [SLOT_COUNT];
    logic [METER_W-1:0] vl_reg [SLOT_COUNT];
    logic [METER_W-1:0] ch_reg [SLOT_COUNT];

    logic               idx_ok;
    logic               sensed;
    logic [SLOT_W-1:0]  slot;
    logic [MASK_W-1:0]  sel;
    logic               cur_on;
    logic               sample_on;
    logic               written;
    logic               err;
    logic               limits_wr;

    always_comb
    begin
        idx_ok    = cmd.relay_index < RELAY_LIMIT;
        sensed    = cmd.relay_index < SENSE_LIMIT;
        slot      = cmd.relay_index[SLOT_W-1:0];
        sel       = MASK_W'(1) << slot;
        cur_on    = on_reg[slot];

        // voltage check first, then the overcurrent trip wins
        if (cmd.bus_voltage > vh_reg[slot])
            sample_on = 1'b0;
        else if (cmd.bus_voltage < vl_reg[slot])
            sample_on = 1'b1;
        else
            sample_on = cur_on;
        if (sensed && cmd.sensor_present && (cmd.channel_current > ch_reg[slot]))
            sample_on = 1'b0;

        on_next     = on_reg;
        manual_next = manual_reg;
        auto_next   = auto_reg;
        safe_next   = safe_reg;
        written     = 1'b0;
        err         = 1'b0;
        limits_wr   = 1'b0;

        unique case (cmd.opcode)
            OP_SET_ALL:
            begin
                on_next = cmd.new_mask & BANK_MASK;
                written = 1'b1;
            end
            OP_POWER_FAIL:
            begin
                safe_next   = 1'b1;
                manual_next = BANK_MASK;
                auto_next   = '0;
                on_next     = ALL_ON_PATTERN & BANK_MASK;
                written     = 1'b1;
            end
            OP_SET_ONE:
            begin
                err = !idx_ok;
                if (idx_ok)
                begin
                    on_next = (cmd.turn_on ? (on_reg | sel) : (on_reg & ~sel)) & BANK_MASK;
                    written = 1'b1;
                end
            end
            OP_TOGGLE:
            begin
                err = !idx_ok;
                if (idx_ok)
                begin
                    on_next = (on_reg ^ sel) & BANK_MASK;
                    written = 1'b1;
                end
            end
            OP_SET_MODE:
            begin
                err = !idx_ok;
                if (idx_ok)
                begin
                    manual_next = (cmd.manual_flag ? (manual_reg | sel) : (manual_reg & ~sel))
                                  & BANK_MASK;
                    if (cmd.manual_flag)
                        auto_next = auto_reg & ~sel & BANK_MASK;
                end
            end
            OP_SET_LIMITS:
            begin
                err = !idx_ok;
                if (idx_ok)
                begin
                    auto_next = (cmd.auto_flag ? (auto_reg | sel) : (auto_reg & ~sel))
                                & BANK_MASK;
                    limits_wr = 1'b1;
                end
            end
            OP_SAMPLE:
            begin
                err = !idx_ok;
                if (idx_ok && !manual_reg[slot] && auto_reg[slot] && (sample_on != cur_on))
                begin
                    on_next = (sample_on ? (on_reg | sel) : (on_reg & ~sel)) & BANK_MASK;
                    written = 1'b1;
                end
            end
            OP_QUERY:
            begin
                err = !idx_ok;
            end
            default:
            begin
                err = !idx_ok;
            end
        endcase

        rsp.relay_outputs   = on_next;
        rsp.outputs_written = written;
        rsp.safe_mode       = safe_next;
        rsp.index_error     = err;
        rsp.selected_on     = idx_ok ? on_next[slot] : 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg     <= '0;
            manual_reg <= BANK_MASK;
            auto_reg   <= '0;
            safe_reg   <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                vh_reg[i] <= VOLT_HIGH_RESET;
                vl_reg[i] <= VOLT_LOW_RESET;
                ch_reg[i] <= CURR_HIGH_RESET;
            end
        end
        else if (en)
        begin
            on_reg     <= on_next;
            manual_reg <= manual_next;
            auto_reg   <= auto_next;
            safe_reg   <= safe_next;
            if (limits_wr)
            begin
                vh_reg[slot] <= cmd.voltage_high_limit;
                vl_reg[slot] <= cmd.voltage_low_limit;
                ch_reg[slot] <= cmd.current_high_limit;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/relay_bank_threshold_controller.sv
// Relay bank threshold controller: top level with command and response registers.
// Takes one command word per clock and returns exactly one status word for each,
// in order. A command is captured in an input register and applied to the relay
// state at the next clock edge at which the response register is free; that same
// edge loads its status word and sets rsp.valid. Sustained rate is one word per
// cycle while the receiver takes each status word, set by the single update stage
// that reads and writes the relay masks and limit tables; the response register
// lets a new command enter while a status word waits.
`default_nettype none

module relay_bank_threshold_controller #(
    parameter int RELAY_COUNT     = 8,
    parameter int SENSED_CHANNELS = 8
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rbtc_cmd_if.sink   cmd,
    rbtc_rsp_if.source rsp
);
    import rbtc_pkg::*;

    cmd_t   cmd_reg;
    logic   cmd_valid_reg, cmd_valid_next;
    rsp_t   rsp_reg;
    logic   rsp_valid_reg;
    rsp_t   exec_rsp;
    logic   rsp_free;
    logic   advance;
    logic   cmd_take;

    assign rsp_free       = !rsp_valid_reg || rsp.ready;
    assign advance        = cmd_valid_reg && rsp_free;
    assign cmd.ready      = !cmd_valid_reg || rsp_free;
    assign cmd_take       = cmd.valid && cmd.ready;
    assign cmd_valid_next = cmd_take || (cmd_valid_reg && !rsp_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else
            cmd_valid_reg <= cmd_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_reg.opcode             <= opcode_t'(cmd.opcode);
            cmd_reg.relay_index        <= cmd.relay_index;
            cmd_reg.turn_on            <= cmd.turn_on;
            cmd_reg.new_mask           <= cmd.new_mask;
            cmd_reg.manual_flag        <= cmd.manual_flag;
            cmd_reg.auto_flag          <= cmd.auto_flag;
            cmd_reg.bus_voltage        <= cmd.bus_voltage;
            cmd_reg.channel_current    <= cmd.channel_current;
            cmd_reg.sensor_present     <= cmd.sensor_present;
            cmd_reg.voltage_high_limit <= cmd.voltage_high_limit;
            cmd_reg.voltage_low_limit  <= cmd.voltage_low_limit;
            cmd_reg.current_high_limit <= cmd.current_high_limit;
        end
    end

    rbtc_exec #(
        .RELAY_COUNT     (RELAY_COUNT),
        .SENSED_CHANNELS (SENSED_CHANNELS)
    ) u_exec (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .cmd   (cmd_reg),
        .rsp   (exec_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (rsp_free)
            rsp_valid_reg <= cmd_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            rsp_reg <= exec_rsp;
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.relay_outputs   = rsp_reg.relay_outputs;
    assign rsp.outputs_written = rsp_reg.outputs_written;
    assign rsp.safe_mode       = rsp_reg.safe_mode;
    assign rsp.index_error     = rsp_reg.index_error;
    assign rsp.selected_on     = rsp_reg.selected_on;

`ifndef SYNTHESIS
    // a rejected index never rewrites the outputs
    a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.index_error |-> !rsp_reg.outputs_written)
        else $error("index error word reports an output rewrite");

    a_err_sel_off: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.index_error |-> !rsp_reg.selected_on)
        else $error("index error word reports selected relay on");

    // safe mode is sticky until reset
    a_safe_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && $past(rsp_valid_reg && rsp_reg.safe_mode) |-> rsp_reg.safe_mode)
        else $error("safe mode dropped without reset");

    // nothing leaves the command register without a place in the response register
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid_reg)
        else $error("command word advanced but no response word held");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_relay_bank_threshold_controller.sv
// Self-checking testbench for the relay bank threshold controller.
`default_nettype none

module tb_relay_bank_threshold_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import rbtc_pkg::*;

    localparam int RELAY_N    = 8;
    localparam int SENSED_N   = 8;
    localparam int MAX_GAP    = 17;
    localparam int IDLE_LIMIT = 400;
    localparam int RANDOM_N   = 650;
    localparam int PRINT_CAP  = 40;
    localparam logic [MASK_W-1:0] BANK_BITS = MASK_W'((1 << RELAY_N) - 1);

    typedef struct {
        cmd_t w;
        bit   fixed;
        rsp_t want;
    } step_t;

    logic clk = 1'b0;
    logic rst_n;

    rbtc_cmd_if cmd_bus ();
    rbtc_rsp_if rsp_bus ();

    relay_bank_threshold_controller #(
        .RELAY_COUNT    (RELAY_N),
        .SENSED_CHANNELS(SENSED_N)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_bus),
        .rsp  (rsp_bus)
    );

    always #4ns clk = ~clk;

    // relay state as the block should hold it
    logic [MASK_W-1:0]  bank_on;
    logic [MASK_W-1:0]  bank_manual;
    logic [MASK_W-1:0]  bank_auto;
    logic [METER_W-1:0] trip_volt_hi [SLOT_COUNT];
    logic [METER_W-1:0] trip_volt_lo [SLOT_COUNT];
    logic [METER_W-1:0] trip_amp_hi  [SLOT_COUNT];
    logic               safe_latched;

    rsp_t  pending_status [$];
    step_t plan [$];
    int    mismatches = 0;
    int    words_seen = 0;
    int    idle_cycles = 0;
    bit    sender_calm = 1'b0;
    bit    receiver_calm = 1'b0;

    function automatic void clear_relay_state();
        bank_on      = '0;
        bank_manual  = BANK_BITS;
        bank_auto    = '0;
        safe_latched = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            trip_volt_hi[i] = VOLT_HIGH_RESET;
            trip_volt_lo[i] = VOLT_LOW_RESET;
            trip_amp_hi[i]  = CURR_HIGH_RESET;
        end
    endfunction

    function automatic rsp_t apply_command(cmd_t w);
        logic [SLOT_W-1:0] slot;
        logic              in_bank;
        logic              cur;
        logic              nxt;
        rsp_t              r;
        slot    = w.relay_index[SLOT_W-1:0];
        in_bank = w.relay_index < RELAY_N;
        r       = '0;
        if (w.opcode == OP_SET_ALL)
        begin
            bank_on           = w.new_mask & BANK_BITS;
            r.outputs_written = 1'b1;
        end
        else if (w.opcode == OP_POWER_FAIL)
        begin
            safe_latched      = 1'b1;
            bank_manual       = BANK_BITS;
            bank_auto         = '0;
            bank_on           = ALL_ON_PATTERN & BANK_BITS;
            r.outputs_written = 1'b1;
        end
        else if (!in_bank)
        begin
            r.index_error = 1'b1;
        end
        else
        begin
            case (w.opcode)
                OP_SET_ONE:
                begin
                    bank_on[slot]     = w.turn_on;
                    r.outputs_written = 1'b1;
                end
                OP_TOGGLE:
                begin
                    bank_on[slot]     = ~bank_on[slot];
                    r.outputs_written = 1'b1;
                end
                OP_SET_MODE:
                begin
                    bank_manual[slot] = w.manual_flag;
                    if (w.manual_flag)
                        bank_auto[slot] = 1'b0;
                end
                OP_SET_LIMITS:
                begin
                    bank_auto[slot]    = w.auto_flag;
                    trip_volt_hi[slot] = w.voltage_high_limit;
                    trip_volt_lo[slot] = w.voltage_low_limit;
                    trip_amp_hi[slot]  = w.current_high_limit;
                end
                OP_SAMPLE:
                begin
                    if (!bank_manual[slot] && bank_auto[slot])
                    begin
                        cur = bank_on[slot];
                        nxt = cur;
                        if (w.bus_voltage > trip_volt_hi[slot])
                            nxt = 1'b0;
                        else if (w.bus_voltage < trip_volt_lo[slot])
                            nxt = 1'b1;
                        // current trip wins over low-voltage turn-on
                        if (w.relay_index < SENSED_N && w.sensor_present
                            && w.channel_current > trip_amp_hi[slot])
                            nxt = 1'b0;
                        if (nxt != cur)
                        begin
                            bank_on[slot]     = nxt;
                            r.outputs_written = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        r.relay_outputs = bank_on;
        r.safe_mode     = safe_latched;
        r.selected_on   = in_bank ? bank_on[slot] : 1'b0;
        return r;
    endfunction

    function automatic cmd_t mk(opcode_t op, logic [INDEX_W-1:0] idx, logic flag,
                                logic [MASK_W-1:0] mask, logic [METER_W-1:0] volts,
                                logic [METER_W-1:0] amps, logic sensor,
                                logic [METER_W-1:0] vh, logic [METER_W-1:0] vl,
                                logic [METER_W-1:0] ch);
        cmd_t w;
        w.opcode             = op;
        w.relay_index        = idx;
        w.turn_on            = flag;
        w.manual_flag        = flag;
        w.auto_flag          = flag;
        w.new_mask           = mask;
        w.bus_voltage        = volts;
        w.channel_current    = amps;
        w.sensor_present     = sensor;
        w.voltage_high_limit = vh;
        w.voltage_low_limit  = vl;
        w.current_high_limit = ch;
        return w;
    endfunction

    // around a limit most of the time, anywhere otherwise
    function automatic logic [METER_W-1:0] near(logic [METER_W-1:0] v);
        case ($urandom_range(0, 3))
            0: return v - 1'b1;
            1: return v;
            2: return v + 1'b1;
            default: return METER_W'($urandom);
        endcase
    endfunction

    function automatic cmd_t random_word();
        logic [127:0]      noise;
        cmd_t              w;
        int                pick;
        logic [SLOT_W-1:0] slot;
        noise = {$urandom, $urandom, $urandom, $urandom};
        w     = noise[$bits(cmd_t)-1:0];
        pick  = $urandom_range(0, 99);
        if (pick < 35)
            w.opcode = OP_SAMPLE;
        else if (pick < 45)
            w.opcode = OP_SET_LIMITS;
        else if (pick < 57)
            w.opcode = OP_SET_MODE;
        else if (pick < 67)
            w.opcode = OP_SET_ONE;
        else if (pick < 75)
            w.opcode = OP_TOGGLE;
        else if (pick < 83)
            w.opcode = OP_SET_ALL;
        else if (pick < 91)
            w.opcode = OP_QUERY;
        else if (pick < 93)
            w.opcode = OP_POWER_FAIL;
        else
            w.opcode = opcode_t'($urandom_range(0, 7));
        if ($urandom_range(0, 9) != 0)
            w.relay_index = INDEX_W'($urandom_range(0, RELAY_N - 1));
        slot = w.relay_index[SLOT_W-1:0];
        case (w.opcode)
            OP_SET_MODE:
                w.manual_flag = ($urandom_range(0, 3) == 0);
            OP_SET_LIMITS:
            begin
                w.auto_flag = ($urandom_range(0, 4) != 0);
                if ($urandom_range(0, 3) != 0)
                begin
                    w.voltage_high_limit = METER_W'(2300 + $urandom_range(0, 400));
                    w.voltage_low_limit  = METER_W'(1800 + $urandom_range(0, 400));
                    w.current_high_limit = METER_W'($urandom_range(0, 8000));
                end
            end
            OP_SAMPLE:
            begin
                w.bus_voltage     = $urandom_range(0, 1) ? near(trip_volt_hi[slot])
                                                         : near(trip_volt_lo[slot]);
                w.channel_current = near(trip_amp_hi[slot]);
                w.sensor_present  = ($urandom_range(0, 9) < 7);
            end
            default:
            begin
            end
        endcase
        return w;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("MISMATCH status word %0d at %0t: %s", words_seen, $realtime, msg);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic send_word(step_t s);
        int   gap;
        rsp_t p;
        if ($urandom_range(0, 29) == 0)
            sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.opcode             <= s.w.opcode;
        cmd_bus.relay_index        <= s.w.relay_index;
        cmd_bus.turn_on            <= s.w.turn_on;
        cmd_bus.new_mask           <= s.w.new_mask;
        cmd_bus.manual_flag        <= s.w.manual_flag;
        cmd_bus.auto_flag          <= s.w.auto_flag;
        cmd_bus.bus_voltage        <= s.w.bus_voltage;
        cmd_bus.channel_current    <= s.w.channel_current;
        cmd_bus.sensor_present     <= s.w.sensor_present;
        cmd_bus.voltage_high_limit <= s.w.voltage_high_limit;
        cmd_bus.voltage_low_limit  <= s.w.voltage_low_limit;
        cmd_bus.current_high_limit <= s.w.current_high_limit;
        cmd_bus.valid              <= 1'b1;
        do @(posedge clk); while (!cmd_bus.ready);
        p = apply_command(s.w);
        pending_status.push_back(s.fixed ? s.want : p);
    endtask

    // status word receiver and checker
    initial
    begin
        int   stall;
        rsp_t got;
        rsp_t want;
        rsp_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                receiver_calm = !receiver_calm;
            stall = receiver_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge clk); while (!rsp_bus.valid);
            words_seen++;
            got = {rsp_bus.relay_outputs, rsp_bus.outputs_written, rsp_bus.safe_mode,
                   rsp_bus.index_error, rsp_bus.selected_on};
            if (pending_status.size() == 0)
            begin
                report_mismatch("status word with none pending");
            end
            else
            begin
                want = pending_status.pop_front();
                check_field("relay_outputs", got.relay_outputs, want.relay_outputs);
                check_field("outputs_written", 8'(got.outputs_written),
                            8'(want.outputs_written));
                check_field("safe_mode", 8'(got.safe_mode), 8'(want.safe_mode));
                check_field("index_error", 8'(got.index_error), 8'(want.index_error));
                check_field("selected_on", 8'(got.selected_on), 8'(want.selected_on));
            end
        end
    end

    // no handshake on either side for too long means a hang
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("** relay_bank_threshold_controller: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        cmd_bus.valid              = 1'b0;
        cmd_bus.opcode             = OP_QUERY;
        cmd_bus.relay_index        = '0;
        cmd_bus.turn_on            = 1'b0;
        cmd_bus.new_mask           = '0;
        cmd_bus.manual_flag        = 1'b0;
        cmd_bus.auto_flag          = 1'b0;
        cmd_bus.bus_voltage        = '0;
        cmd_bus.channel_current    = '0;
        cmd_bus.sensor_present     = 1'b0;
        cmd_bus.voltage_high_limit = '0;
        cmd_bus.voltage_low_limit  = '0;
        cmd_bus.current_high_limit = '0;
        rst_n                      = 1'b0;
        clear_relay_state();

        // directed words; fixed status only where it is obvious
        plan.push_back('{mk(OP_QUERY, 4'd0, 0, 8'h00, 0, 0, 0, 0, 0, 0), 1'b1,
                         rsp_t'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}});
        plan.push_back('{mk(OP_SET_ONE, 4'd15, 1, 8'h00, 0, 0, 0, 0, 0, 0), 1'b1,
                         rsp_t'{8'h00, 1'b0, 1'b0, 1'b1, 1'b0}});
        plan.push_back('{mk(OP_SET_ALL, 4'd0, 0, 8'hFF, 0, 0, 0, 0, 0, 0), 1'b1,
                         rsp_t'{8'hFF, 1'b1, 1'b0, 1'b0, 1'b1}});
        plan.push_back('{mk(OP_SET_ALL, 4'd9, 0, 8'h00, 0, 0, 0, 0, 0, 0), 1'b1,
                         rsp_t'{8'h00, 1'b1, 1'b0, 1'b0, 1'b0}});
        plan.push_back('{mk(OP_SET_ONE, 4'd7, 1, 8'h00, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk(OP_TOGGLE, 4'd7, 0, 8'h00, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk(OP_TOGGLE, 4'd8, 0, 8'h00, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        // manual relay ignores samples
        plan.push_back('{mk(OP_SAMPLE, 4'd0, 0, 8'h00, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk(OP_SET_MODE, 4'd0, 0, 8'h00, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk(OP_SET_LIMITS, 4'd0, 1, 8'h00, 0, 0, 0, 2500, 2000, 5000),
                         1'b0, '0});
        plan.push_back('{mk(OP_SAMPLE, 4'd0, 0, 8'h00, 1999, 0, 0, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk(OP_SAMPLE, 4'd0, 0, 8'h00, 2501, 0, 0, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk(OP_SAMPLE, 4'd0, 0, 8'h00, 2000, 0, 0, 0, 0, 0), 1'b0, '0});
        // absent sensor: high current has no effect
        plan.push_back('{mk(OP_SAMPLE, 4'd0, 0, 8'h00, 1000, 16'hFFFF, 0, 0, 0, 0),
                         1'b0, '0});
        // low voltage and high current together end off
        plan.push_back('{mk(OP_SAMPLE, 4'd0, 0, 8'h00, 0, 5001, 1, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk(OP_SAMPLE, 4'd0, 0, 8'h00, 0, 5000, 1, 0, 0, 0), 1'b0, '0});
        // inconsistent limits, low above high
        plan.push_back('{mk(OP_SET_MODE, 4'd3, 0, 8'h00, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk(OP_SET_LIMITS, 4'd3, 1, 8'h00, 0, 0, 0, 0, 16'hFFFF, 0),
                         1'b0, '0});
        plan.push_back('{mk(OP_SAMPLE, 4'd3, 0, 8'h00, 0, 0, 1, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk(OP_SAMPLE, 4'd3, 0, 8'h00, 16'hFFFF, 0, 1, 0, 0, 0),
                         1'b0, '0});
        // manual again clears auto enable
        plan.push_back('{mk(OP_SET_MODE, 4'd0, 1, 8'h00, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk(OP_SAMPLE, 4'd0, 0, 8'h00, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        plan.push_back('{mk(OP_SET_LIMITS, 4'd12, 1, 8'h00, 0, 0, 0, 1, 1, 1), 1'b0, '0});
        plan.push_back('{mk(OP_POWER_FAIL, 4'd13, 0, 8'h00, 0, 0, 0, 0, 0, 0), 1'b1,
                         rsp_t'{8'hFF, 1'b1, 1'b1, 1'b0, 1'b0}});
        plan.push_back('{mk(OP_SET_ALL, 4'd5, 0, 8'h5A, 0, 0, 0, 0, 0, 0), 1'b0, '0});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_word(plan[i]);
        for (int n = 0; n < RANDOM_N; n++)
            send_word('{random_word(), 1'b0, '0});
        cmd_bus.valid <= 1'b0;

        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("** relay_bank_threshold_controller: PASSED **");
        else
            $display("** relay_bank_threshold_controller: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// File: relay_bank_threshold_controller.f
hdl/rbtc_pkg.sv
hdl/rbtc_cmd_if.sv
hdl/rbtc_rsp_if.sv
hdl/rbtc_exec.sv
hdl/relay_bank_threshold_controller.sv
tb/sv/tb_relay_bank_threshold_controller.sv
